// ----- design/fvn_pkg.sv -----
// Package for the fractal value noise height unit.
// Holds hash constants, coordinate types, register indexes and the small
// arithmetic helpers used by the octave cells, plus the shaping constants.
`default_nettype none
package fvn_pkg;

	typedef logic signed [47:0] coord_t;
	typedef logic [23:0] noise_t;

	typedef enum logic [1:0] {
		REG_SEED         = 2'd0,
		REG_INV_SIZE     = 2'd1,
		REG_HEIGHT_SCALE = 2'd2
	} reg_index_t;

	localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Z    = 32'd668265263;
	localparam logic [31:0] HASH_MUL_SEED = 32'd1442695041;
	localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;
	localparam logic [31:0] DETAIL_SEED_XOR = 32'h9e3779b9;
	localparam logic [31:0] OCT_SEED_STEP   = 32'd1013;
	localparam logic [31:0] BIOME_SEED_ADD  = 32'd12345;

	localparam logic [31:0] SEED_RESET   = 32'd12648430;
	localparam logic [31:0] INV_RESET    = 32'd23860929;
	localparam logic [15:0] SCALE_RESET  = 16'd2304;

	localparam coord_t BROAD_X_OFS  = 48'sd1310720;
	localparam coord_t BROAD_Z_OFS  = -48'sd1114112;
	localparam coord_t DETAIL_X_OFS = -48'sd458752;
	localparam coord_t DETAIL_Z_OFS = 48'sd720896;

	localparam logic [39:0] BROAD_WEIGHT  = 40'd53740;
	localparam logic [39:0] DETAIL_WEIGHT = 40'd11796;
	localparam logic [31:0] EDGE_START    = 32'd27525;
	localparam logic [48:0] EDGE_SLOPE    = 49'd112993;
	localparam logic [32:0] FLAT_MAX      = 33'd65536;
	localparam logic [31:0] FLAT_DEPTH    = 32'd22938;
	localparam logic [16:0] UNIT_Q16      = 17'd65536;
	localparam logic [31:0] DROP_Q16      = 32'd27525;

	function automatic logic [24:0] smooth24(input logic [31:0] ff, input logic [15:0] f);
		logic [17:0] t;
		logic [49:0] p;
		t = 18'd196608 - {1'b0, f, 1'b0};
		p = 50'(ff) * 50'(t);
		return p[48:24];
	endfunction

	function automatic logic [31:0] hash_pre(input logic [31:0] p);
		return p ^ (p >> 13);
	endfunction

	function automatic noise_t hash_fin(input logic [31:0] m);
		logic [31:0] t;
		t = m ^ (m >> 16);
		return t[23:0];
	endfunction

	function automatic noise_t lerp24(input noise_t a, input noise_t b, input logic [24:0] s);
		logic signed [24:0] d;
		logic signed [25:0] sv;
		logic signed [51:0] p;
		logic signed [26:0] r;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		sv = $signed({1'b0, s});
		p = d * sv;
		r = $signed({3'b0, a}) + p[50:24];
		return r[23:0];
	endfunction

endpackage
`default_nettype wire

// ----- design/fractal_value_noise_height_unit.sv -----
// Terrain height and biome class from fractal value noise, one item per cycle.
// Each octave cell is five pipeline stages and three cell chains run side by
// side. A result that is not taken moves to a skid register; in_ready drops
// only while that register is full. Reset clears all valid flags and loads
// the configuration defaults; there is no memory and no clearing pass.
`default_nettype none
module fractal_value_noise_height_unit import fvn_pkg::*; #(
	parameter int OCTAVES = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] x_coord,
	input  logic signed [23:0] z_coord,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] height,
	output logic [1:0]         biome_class,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int STAGES = 8 + 5 * OCTAVES;
	localparam int FAC_DELAY = 2 + 5 * OCTAVES;

	logic [31:0] seed_q, inv_size_q;
	logic [15:0] height_scale_q;

	logic en, take;
	logic [STAGES-1:0] v_q;

	logic signed [56:0] px, pz;
	logic signed [32:0] nx_s1, nz_s1;
	coord_t nxw, nzw;
	logic signed [46:0] pbx, pbz;
	logic [32:0] anx, anz;
	coord_t cbx_s2, cbz_s2, cdx_s2, cdz_s2, bix_s2, biz_s2;
	logic [31:0] rim_s2;
	logic [48:0] slope;
	logic [16:0] flat_s3;
	logic [31:0] fp;
	logic [16:0] factor_s4, factor_d;

	noise_t broad, detail, bio;
	logic signed [23:0] shp_height;
	logic [1:0] shp_biome;

	logic signed [23:0] height_q, sk_height_q;
	logic [1:0] biome_q, sk_biome_q;
	logic out_valid_q, sk_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q         <= SEED_RESET;
			inv_size_q     <= INV_RESET;
			height_scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEED:         seed_q <= cfg_data;
				REG_INV_SIZE:     inv_size_q <= cfg_data;
				REG_HEIGHT_SCALE: height_scale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign en       = !sk_full_q;
	assign in_ready = en;
	assign take     = en && v_q[STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[STAGES-2:0], in_valid};
		end
	end

	assign px  = x_coord * $signed({1'b0, inv_size_q});
	assign pz  = z_coord * $signed({1'b0, inv_size_q});
	assign nxw = {{15{nx_s1[32]}}, nx_s1};
	assign nzw = {{15{nz_s1[32]}}, nz_s1};
	assign pbx = nx_s1 * 14'sd6554;
	assign pbz = nz_s1 * 14'sd6554;
	assign anx = nx_s1[32] ? 33'(-nx_s1) : 33'(nx_s1);
	assign anz = nz_s1[32] ? 33'(-nz_s1) : 33'(nz_s1);
	assign slope = 49'(rim_s2 - EDGE_START) * EDGE_SLOPE;
	assign fp = 32'(flat_s3) * FLAT_DEPTH;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1 <= px[56:24];
			nz_s1 <= pz[56:24];

			cbx_s2 <= (nxw <<< 1) + nxw + BROAD_X_OFS;
			cbz_s2 <= (nzw <<< 1) + nzw + BROAD_Z_OFS;
			cdx_s2 <= (nxw <<< 4) - nxw + DETAIL_X_OFS;
			cdz_s2 <= (nzw <<< 4) - nzw + DETAIL_Z_OFS;
			bix_s2 <= {{17{pbx[46]}}, pbx[46:16]};
			biz_s2 <= {{17{pbz[46]}}, pbz[46:16]};
			rim_s2 <= (anx > anz) ? anx[31:0] : anz[31:0];

			if (rim_s2 <= EDGE_START) begin
				flat_s3 <= 17'd0;
			end else if (slope[48:16] > FLAT_MAX) begin
				flat_s3 <= FLAT_MAX[16:0];
			end else begin
				flat_s3 <= slope[32:16];
			end

			factor_s4 <= UNIT_Q16 - 17'(fp[31:16]);
		end
	end

	fvn_delay #(
		.WIDTH (17),
		.DEPTH (FAC_DELAY)
	) u_fac_delay (
		.clk     (clk),
		.en      (en),
		.data    (factor_s4),
		.delayed (factor_d)
	);

	fvn_fractal #(.OCTAVES(OCTAVES)) u_broad (
		.clk     (clk),
		.en      (en),
		.coord_x (cbx_s2),
		.coord_z (cbz_s2),
		.seed    (seed_q),
		.noise   (broad)
	);

	fvn_fractal #(.OCTAVES(OCTAVES)) u_detail (
		.clk     (clk),
		.en      (en),
		.coord_x (cdx_s2),
		.coord_z (cdz_s2),
		.seed    (seed_q ^ DETAIL_SEED_XOR),
		.noise   (detail)
	);

	fvn_fractal #(.OCTAVES(OCTAVES)) u_bio (
		.clk     (clk),
		.en      (en),
		.coord_x (bix_s2),
		.coord_z (biz_s2),
		.seed    (seed_q + BIOME_SEED_ADD),
		.noise   (bio)
	);

	fvn_shape u_shape (
		.clk          (clk),
		.en           (en),
		.broad        (broad),
		.detail       (detail),
		.bio          (bio),
		.height_scale (height_scale_q),
		.factor       (factor_d),
		.height       (shp_height),
		.biome_class  (shp_biome)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_full_q   <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (sk_full_q) begin
				out_valid_q <= 1'b1;
				sk_full_q   <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			sk_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (sk_full_q) begin
				height_q <= sk_height_q;
				biome_q  <= sk_biome_q;
			end else begin
				height_q <= shp_height;
				biome_q  <= shp_biome;
			end
		end else if (take) begin
			sk_height_q <= shp_height;
			sk_biome_q  <= shp_biome;
		end
	end

	assign out_valid   = out_valid_q;
	assign height      = height_q;
	assign biome_class = biome_q;

endmodule
`default_nettype wire

// ----- design/fvn_cell.sv -----
// One octave cell: hashes the four cell corners, smooths the fraction and
// blends, then folds the value into the running octave sum. Uses fvn_pkg.
`default_nettype none
module fvn_cell import fvn_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  coord_t      coord_x,
	input  coord_t      coord_z,
	input  logic [31:0] seed,
	input  logic [31:0] acc,
	output coord_t      next_x,
	output coord_t      next_z,
	output logic [31:0] next_acc
);

	logic [31:0] hx_s1, hz_s1, hsd_s1, ffx_s1, ffz_s1;
	logic [15:0] fx_s1, fz_s1;
	logic [31:0] g_s2 [4];
	logic [24:0] sx_s2, sz_s2;
	logic [31:0] m_s3 [4];
	logic [24:0] sx_s3, sz_s3;
	noise_t      ab_s4, cd_s4;
	logic [24:0] sz_s4;
	logic [31:0] acc_s5;
	coord_t      x_s [1:5];
	coord_t      z_s [1:5];
	logic [31:0] acc_s [1:4];
	logic [31:0] hxn, hzn;

	assign hxn = hx_s1 + HASH_MUL_X;
	assign hzn = hz_s1 + HASH_MUL_Z;

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s1  <= coord_x[47:16] * HASH_MUL_X;
			hz_s1  <= coord_z[47:16] * HASH_MUL_Z;
			hsd_s1 <= seed * HASH_MUL_SEED;
			ffx_s1 <= 32'(coord_x[15:0]) * 32'(coord_x[15:0]);
			ffz_s1 <= 32'(coord_z[15:0]) * 32'(coord_z[15:0]);
			fx_s1  <= coord_x[15:0];
			fz_s1  <= coord_z[15:0];
			x_s[1] <= coord_x <<< 1;
			z_s[1] <= coord_z <<< 1;
			acc_s[1] <= acc;

			g_s2[0] <= hash_pre(hx_s1 ^ hz_s1 ^ hsd_s1);
			g_s2[1] <= hash_pre(hxn ^ hz_s1 ^ hsd_s1);
			g_s2[2] <= hash_pre(hx_s1 ^ hzn ^ hsd_s1);
			g_s2[3] <= hash_pre(hxn ^ hzn ^ hsd_s1);
			sx_s2 <= smooth24(ffx_s1, fx_s1);
			sz_s2 <= smooth24(ffz_s1, fz_s1);

			for (int i = 0; i < 4; i++) begin
				m_s3[i] <= g_s2[i] * HASH_MUL_MIX;
			end
			sx_s3 <= sx_s2;
			sz_s3 <= sz_s2;

			ab_s4 <= lerp24(hash_fin(m_s3[0]), hash_fin(m_s3[1]), sx_s3);
			cd_s4 <= lerp24(hash_fin(m_s3[2]), hash_fin(m_s3[3]), sx_s3);
			sz_s4 <= sz_s3;

			acc_s5 <= {acc_s[4][30:0], 1'b0} + 32'(lerp24(ab_s4, cd_s4, sz_s4));

			for (int i = 2; i <= 5; i++) begin
				x_s[i] <= x_s[i-1];
				z_s[i] <= z_s[i-1];
			end
			for (int i = 2; i <= 4; i++) begin
				acc_s[i] <= acc_s[i-1];
			end
		end
	end

	assign next_x   = x_s[5];
	assign next_z   = z_s[5];
	assign next_acc = acc_s5;

endmodule
`default_nettype wire

// ----- design/fvn_fractal.sv -----
// Fractal noise: a chain of octave cells followed by a two stage divide of
// the weighted sum by 2^OCTAVES-1. Uses fvn_pkg and fvn_cell.
`default_nettype none
module fvn_fractal import fvn_pkg::*; #(
	parameter int OCTAVES = 5
) (
	input  logic        clk,
	input  logic        en,
	input  coord_t      coord_x,
	input  coord_t      coord_z,
	input  logic [31:0] seed,
	output noise_t      noise
);

	localparam int SHIFT = 24 + OCTAVES;
	localparam logic [63:0] DIVISOR = (64'd1 << OCTAVES) - 64'd1;
	localparam logic [63:0] RECIP = (64'd1 << SHIFT) / DIVISOR;

	coord_t      cx [OCTAVES+1];
	coord_t      cz [OCTAVES+1];
	logic [31:0] sm [OCTAVES+1];
	logic [57:0] prod;
	noise_t      q0_s1;
	logic [31:0] sum_s1;
	logic [32:0] qk, rem;
	noise_t      noise_s2;

	assign cx[0] = coord_x;
	assign cz[0] = coord_z;
	assign sm[0] = 32'd0;

	for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
		fvn_cell u_cell (
			.clk      (clk),
			.en       (en),
			.coord_x  (cx[k]),
			.coord_z  (cz[k]),
			.seed     (seed + 32'(k) * OCT_SEED_STEP),
			.acc      (sm[k]),
			.next_x   (cx[k+1]),
			.next_z   (cz[k+1]),
			.next_acc (sm[k+1])
		);
	end

	assign prod = 58'(sm[OCTAVES]) * 58'(RECIP[25:0]);
	assign qk   = (33'(q0_s1) << OCTAVES) - 33'(q0_s1);
	assign rem  = 33'(sum_s1) - qk;

	always_ff @(posedge clk) begin
		if (en) begin
			q0_s1  <= prod[SHIFT+23:SHIFT];
			sum_s1 <= sm[OCTAVES];
			if (rem >= DIVISOR[32:0]) begin
				noise_s2 <= q0_s1 + 24'd1;
			end else begin
				noise_s2 <= q0_s1;
			end
		end
	end

	assign noise = noise_s2;

endmodule
`default_nettype wire

// ----- design/fvn_delay.sv -----
// Enabled delay line of fixed depth that keeps side data in step with the
// noise pipeline. No dependencies.
`default_nettype none
module fvn_delay #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 27
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] data,
	output logic [WIDTH-1:0] delayed
);

	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= data;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign delayed = line_q[DEPTH-1];

endmodule
`default_nettype wire

// ----- design/fvn_shape.sv -----
// Height shaping: mixes the two fractal noises, applies the scale, the edge
// flattening factor and the downward offset, and picks the biome quarter.
// Uses fvn_pkg.
`default_nettype none
module fvn_shape import fvn_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  noise_t             broad,
	input  noise_t             detail,
	input  noise_t             bio,
	input  logic [15:0]        height_scale,
	input  logic [16:0]        factor,
	output logic signed [23:0] height,
	output logic [1:0]         biome_class
);

	logic [39:0] mix_sum;
	logic [23:0] mix_s1;
	logic [39:0] hraw_s2;
	logic [56:0] hprod;
	logic [40:0] h2_s3;
	logic [38:0] off_q;
	logic signed [41:0] h3;
	logic signed [23:0] height_s4;
	logic [1:0] bc_s1, bc_s2, bc_s3, bc_s4;

	assign mix_sum = 40'(broad) * BROAD_WEIGHT + 40'(detail) * DETAIL_WEIGHT;
	assign hprod   = 57'(hraw_s2) * 57'(factor);
	assign h3      = $signed({1'b0, h2_s3}) - $signed({3'b0, off_q});

	always_ff @(posedge clk) begin
		off_q <= {31'(32'(height_scale) * DROP_Q16), 8'd0};
		if (en) begin
			mix_s1    <= mix_sum[39:16];
			bc_s1     <= bio[23:22];
			hraw_s2   <= 40'(mix_s1) * 40'(height_scale);
			bc_s2     <= bc_s1;
			h2_s3     <= hprod[56:16];
			bc_s3     <= bc_s2;
			height_s4 <= {{6{h3[41]}}, h3[41:24]};
			bc_s4     <= bc_s3;
		end
	end

	assign height      = height_s4;
	assign biome_class = bc_s4;

endmodule
`default_nettype wire

// ----- dv/fvn_height_checker.sv -----
// Checker for the fractal value noise height unit: watches both channels and
// the register port, predicts height and biome class for every input transfer.
// Depends on fvn_pkg for register indexes and hash constants.
`timescale 1ns / 1ps
module fvn_height_checker import fvn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [23:0] x_coord,
	input  logic signed [23:0] z_coord,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [23:0] height,
	input  logic [1:0]         biome_class,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);
	localparam int OCTAVES = 5;

	typedef struct packed {
		logic signed [23:0] height;
		logic [1:0]         biome;
	} terrain_t;

	terrain_t   expected_terrain[$];
	bit [31:0]  seed_r;
	bit [31:0]  inv_size_r;
	bit [15:0]  scale_r;

	function automatic longint corner_noise(bit [31:0] cx, bit [31:0] cz, bit [31:0] sd);
		bit [31:0] h;
		h = cx * HASH_MUL_X;
		h ^= cz * HASH_MUL_Z;
		h ^= sd * HASH_MUL_SEED;
		h = (h ^ (h >> 13)) * HASH_MUL_MIX;
		h ^= h >> 16;
		return longint'(h[23:0]);
	endfunction

	function automatic longint smoothstep_q24(longint f);
		return (f * f * (196608 - 2 * f)) >>> 24;
	endfunction

	function automatic longint mix_q24(longint a, longint b, longint s);
		return a + (((b - a) * s) >>> 24);
	endfunction

	function automatic longint lattice_noise(longint cx, longint cz, bit [31:0] sd);
		longint ixl, izl, sx, sz, ab, cd;
		bit [31:0] ix, iz;
		ixl = cx >>> 16;
		izl = cz >>> 16;
		ix = ixl[31:0];
		iz = izl[31:0];
		sx = smoothstep_q24(cx & 64'hFFFF);
		sz = smoothstep_q24(cz & 64'hFFFF);
		ab = mix_q24(corner_noise(ix, iz, sd), corner_noise(ix + 1, iz, sd), sx);
		cd = mix_q24(corner_noise(ix, iz + 1, sd), corner_noise(ix + 1, iz + 1, sd), sx);
		return mix_q24(ab, cd, sz);
	endfunction

	function automatic longint octave_sum(longint cx, longint cz, bit [31:0] sd);
		longint sum;
		longint mul;
		sum = 0;
		for (int o = 0; o < OCTAVES; o++) begin
			mul = longint'(1) << o;
			sum += lattice_noise(cx * mul, cz * mul, sd + o * OCT_SEED_STEP) *
				(longint'(1) << (OCTAVES - 1 - o));
		end
		return sum / ((longint'(1) << OCTAVES) - 1);
	endfunction

	function automatic terrain_t terrain_at(logic signed [23:0] x, logic signed [23:0] z);
		terrain_t t;
		longint nx, nz, broad, detail, mix, h, ax, az, rim, flat, factor, res, bio;
		nx = (longint'(x) * longint'(inv_size_r)) >>> 24;
		nz = (longint'(z) * longint'(inv_size_r)) >>> 24;
		broad = octave_sum(nx * 3 + 20 * 65536, nz * 3 - 17 * 65536, seed_r);
		detail = octave_sum(nx * 15 - 7 * 65536, nz * 15 + 11 * 65536,
			seed_r ^ DETAIL_SEED_XOR);
		mix = (broad * 53740 + detail * 11796) >>> 16;
		h = mix * longint'(scale_r);
		ax = nx < 0 ? -nx : nx;
		az = nz < 0 ? -nz : nz;
		rim = ax > az ? ax : az;
		flat = 0;
		if (rim > 27525) begin
			flat = ((rim - 27525) * 112993) >>> 16;
			if (flat > 65536)
				flat = 65536;
		end
		factor = 65536 - ((flat * 22938) >>> 16);
		h = (h * factor) >>> 16;
		h -= longint'(scale_r) * 27525 * 256;
		res = h >>> 24;
		if (res > 8388607)
			res = 8388607;
		if (res < -8388608)
			res = -8388608;
		bio = octave_sum((nx * 6554) >>> 16, (nz * 6554) >>> 16, seed_r + BIOME_SEED_ADD);
		t.height = res[23:0];
		t.biome = bio[23:22];
		return t;
	endfunction

	assign pending = expected_terrain.size();

	always @(posedge clk or negedge arst_n) begin
		terrain_t want;
		int misses;
		if (!arst_n) begin
			seed_r <= SEED_RESET;
			inv_size_r <= INV_RESET;
			scale_r <= SCALE_RESET;
			fail_count <= 0;
			checked <= 0;
			expected_terrain.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SEED: seed_r <= cfg_data;
					REG_INV_SIZE: inv_size_r <= cfg_data;
					REG_HEIGHT_SCALE: scale_r <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_terrain = {expected_terrain, terrain_at(x_coord, z_coord)};
			if (out_valid && out_ready) begin
				checked <= checked + 1;
				misses = 0;
				if (expected_terrain.size() == 0) begin
					$display("%0t: unexpected result height=%0d biome=%0d", $time,
						height, biome_class);
					misses = 1;
				end else begin
					want = expected_terrain.pop_front();
					if (want.height !== height) begin
						$display("%0t: height expected %0d actual %0d", $time,
							want.height, height);
						misses++;
					end
					if (want.biome !== biome_class) begin
						$display("%0t: biome expected %0d actual %0d", $time,
							want.biome, biome_class);
						misses++;
					end
				end
				fail_count <= fail_count + misses;
			end
		end
	end
endmodule

// ----- dv/testbench.sv -----
// Top of the height unit testbench: clock, reset, register writes, coordinate
// stimulus and result back-pressure. Depends on fvn_pkg, fvn_height_checker and the height unit.
`timescale 1ns / 1ps
module testbench import fvn_pkg::*;;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [23:0] x_coord = '0;
	logic signed [23:0] z_coord = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [23:0] height;
	logic [1:0]         biome_class;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	int                 fail_count, pending, checked;
	int                 quiet_cycles = 0;
	bit                 steady = 0;
	bit                 hold_request = 0;
	int                 coords_sent = 0;

	always #5 clk = ~clk;

	fractal_value_noise_height_unit uut (.*);
	fvn_height_checker checker_i (.*);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				hold_request = 0;
				repeat (300) @(posedge clk);
			end
			out_ready <= steady || ($urandom_range(99) >= 14);
		end
	end

	task automatic send_coord(logic signed [23:0] x, logic signed [23:0] z);
		while (!steady && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		x_coord <= x;
		z_coord <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		coords_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return $signed(24'($urandom_range(8191))) - 24'sd4096;
			2: return $signed(24'($urandom_range(131071))) - 24'sd65536;
			default: return $urandom_range(1) ? 24'sh7FFFFF - 24'($urandom_range(255))
				: 24'sh800000 + 24'($urandom_range(255));
		endcase
	endfunction

	initial begin
		logic signed [23:0] corner_vals[6];
		corner_vals = '{24'sh7FFFFF, 24'sh800000, 24'sd0, -24'sd1, 24'sd1, 24'sd256};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 6; i++)
			send_coord(corner_vals[i], corner_vals[5 - i]);
		send_coord(24'sh7FFFFF, 24'sh7FFFFF);
		send_coord(24'sh800000, 24'sh800000);
		wait_drained();
		write_reg(REG_INV_SIZE, 32'd0);
		write_reg(REG_UNUSED, 32'hFFFFFFFF);
		send_coord(24'sh7FFFFF, 24'sh800000);
		send_coord(24'sd12345, -24'sd999);
		wait_drained();
		write_reg(REG_INV_SIZE, 32'hFFFFFFFF);
		write_reg(REG_HEIGHT_SCALE, 32'h0000FFFF);
		write_reg(REG_SEED, 32'hFFFFFFFF);
		for (int i = 0; i < 6; i++)
			send_coord(corner_vals[i], corner_vals[i]);
		wait_drained();
		write_reg(REG_HEIGHT_SCALE, 32'd0);
		write_reg(REG_SEED, 32'd0);
		send_coord(24'sd100, 24'sd5000);
		send_coord(24'sh7FFFFF, -24'sd70000);

		for (int phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase)
				0: write_reg(REG_INV_SIZE, INV_RESET);
				1: write_reg(REG_INV_SIZE, 32'd1 << $urandom_range(31));
				2: write_reg(REG_INV_SIZE, 32'hFFFFFFFF);
				default: write_reg(REG_INV_SIZE, $urandom);
			endcase
			write_reg(REG_SEED, phase == 1 ? 32'hFFFFFFFF : $urandom);
			write_reg(REG_HEIGHT_SCALE, phase == 2 ? 32'h0000FFFF : $urandom_range(65535));
			steady = (phase == 3);
			if (phase == 1)
				hold_request = 1;
			for (int i = 0; i < 115; i++) begin
				send_coord(rand_coord(), rand_coord());
				if (phase == 4 && i == 60) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
			steady = 0;
		end

		wait_drained();
		$display("Sent %0d coordinate pairs and checked %0d results", coords_sent, checked);
		$display("over default, zero, maximum and random scale, seed and size settings.");
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
